// ----- hw/rtl/gn2t_pkg.sv -----
// ============================================================================
// gn2t_pkg
// Shared types, constants and helpers for the 2D gradient noise block.
// ============================================================================
package gn2t_pkg;

  localparam int unsigned TABLE_SIZE_DEF = 256;
  localparam int unsigned GRAD_BITS_DEF  = 16;

  localparam int unsigned CMD_W       = 2;
  localparam int unsigned COORD_W     = 32;
  localparam int unsigned VAL_W       = 20;
  localparam int unsigned IN_TDATA_W  = 144;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned PERM_W      = 8;
  localparam int unsigned QUEUE_DEPTH = 2;

  // datapath widths
  localparam int unsigned MUL_W  = 33;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned NV_W   = 48;
  localparam int unsigned SUM_W  = 40;
  localparam int unsigned DIV_W  = 48;
  localparam int unsigned CNT_W  = $clog2(DIV_W);

  localparam int unsigned ONE_Q16  = 65536;
  localparam int unsigned HALF_Q16 = 32768;
  localparam int unsigned SMOOTH_K = 3 * ONE_Q16;

  localparam logic signed [NV_W-1:0] OUT_MAX = NV_W'(524287);
  localparam logic signed [NV_W-1:0] OUT_MIN = -NV_W'(524288);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_PERM = 2'd0,
    CMD_LOAD_GRAD = 2'd1,
    CMD_NOISE     = 2'd2,
    CMD_TURB      = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [7:0]          entry_index;
    logic [PERM_W-1:0]   perm_value;
    logic signed [15:0]  grad_x;
    logic signed [15:0]  grad_y;
    logic [COORD_W-1:0]  coord_x;
    logic [COORD_W-1:0]  coord_y;
    logic [COORD_W-1:0]  start_freq;
  } item_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_TMX, ST_TMY, ST_TXY,
    ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6,
    ST_GADR, ST_GMX, ST_GMY, ST_GSUM,
    ST_SX1, ST_SX2, ST_SX3, ST_SY1, ST_SY2, ST_SY3,
    ST_BA, ST_BB, ST_BC, ST_BD, ST_BE,
    ST_DIV, ST_ACC, ST_DONE
  } state_e;

  function automatic logic [VAL_W-1:0] sat_val(input logic signed [NV_W-1:0] v);
    logic signed [NV_W-1:0] r;
    r = v;
    if (v > OUT_MAX) r = OUT_MAX;
    if (v < OUT_MIN) r = OUT_MIN;
    return r[VAL_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/gradient_noise_2d_turbulence.sv -----
// ============================================================================
// gradient_noise_2d_turbulence
// 2D gradient noise and turbulence engine with loadable lattice tables.
// ============================================================================
// Usage:
//  - Input stream (s_axis): one transaction per command. tuser carries the
//    command: load permutation entry, load gradient entry, noise, turbulence.
//  - Output stream (m_axis): one transaction per noise or turbulence command,
//    in command order; loads give none.
//  - A two-entry queue sits between the input decoder and the execution
//    sequencer, so commands are taken while an earlier one still runs.
//  - Load: written to its table as the sequencer pops it from the queue.
//  - Noise: 6 permutation reads, 4 gradient reads with two multiplies
//    each, two smoothstep evaluations and three blends, all on one shared
//    33x33 multiplier.
//  - Turbulence: up to 16 octaves (one octave per halving of start_freq
//    while it is at least one); the bit-serial divide of the 48-bit
//    numerator by the frequency dominates each octave.
//  - Reset clears the sequencer state, output valid and queue pointers.
//    Table contents are undefined until loaded; no clearing pass runs.
//  - When m_axis_tready is low the result is held in the output register; the
//    sequencer finishes its next command and then waits for that register.
// ============================================================================
module gradient_noise_2d_turbulence
  import gn2t_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int unsigned GRAD_BITS  = GRAD_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // entry_index[7:0], perm_value[15:8], grad_x[31:16], grad_y[47:32],
  // coord_x[79:48], coord_y[111:80], start_freq[143:112]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // cmd[1:0]
  input  logic [CMD_W-1:0]       s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // value[19:0], zeros above
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic             head_valid;
  item_t            head;
  logic             pop;
  logic [VAL_W-1:0] value;

  gn2t_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .s_user_i     (s_axis_tuser),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  gn2t_back #(
    .TABLE_SIZE (TABLE_SIZE),
    .GRAD_BITS  (GRAD_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_value_o    (value)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - VAL_W)'(0), value};

endmodule

// ----- hw/rtl/gn2t_ram.sv -----
// ============================================================================
// gn2t_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module gn2t_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hw/rtl/gn2t_front.sv -----
// ============================================================================
// gn2t_front
// Input side: decodes the command kind, unpacks the item and queues it.
// ============================================================================
module gn2t_front
  import gn2t_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  output logic                  s_ready_o,
  input  logic [IN_TDATA_W-1:0] s_data_i,
  input  logic [CMD_W-1:0]      s_user_i,
  output logic                  head_valid_o,
  output item_t                 head_o,
  input  logic                  pop_i
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  item_t            slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   count_q;
  item_t            item;
  logic             push, pop;

  always_comb begin
    item.cmd         = cmd_e'(s_user_i);
    item.entry_index = s_data_i[7:0];
    item.perm_value  = s_data_i[15:8];
    item.grad_x      = s_data_i[31:16];
    item.grad_y      = s_data_i[47:32];
    item.coord_x     = s_data_i[79:48];
    item.coord_y     = s_data_i[111:80];
    item.start_freq  = s_data_i[143:112];
  end

  assign s_ready_o    = (count_q != (PTR_W+1)'(QUEUE_DEPTH));
  assign push         = s_valid_i && s_ready_o;
  assign pop          = pop_i && head_valid_o;
  assign head_valid_o = (count_q != '0);
  assign head_o       = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      case ({push, pop})
        2'b10:   count_q <= count_q + (PTR_W+1)'(1);
        2'b01:   count_q <= count_q - (PTR_W+1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PTR_W+1)'(QUEUE_DEPTH))
    else $error("queue count overflow");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 && !push) |=> (count_q == '0))
    else $error("queue count moved without a transaction");
`endif

endmodule

// ----- hw/rtl/gn2t_back.sv -----
// ============================================================================
// gn2t_back
// Execution side: table loads, lattice lookups, blending, turbulence octaves.
// ============================================================================
module gn2t_back
  import gn2t_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int unsigned GRAD_BITS  = GRAD_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  item_t            head_i,
  output logic             pop_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output logic [VAL_W-1:0] m_value_o
);

  localparam int unsigned CELL_W = $clog2(TABLE_SIZE);
  localparam int unsigned GW     = 2 * GRAD_BITS;

  state_e state_q, state_d;

  // stores
  logic              p_we, g_we;
  logic [CELL_W-1:0] p_raddr, g_raddr;
  logic [PERM_W-1:0] p_rdata;
  logic [GW-1:0]     g_rdata;

  // working registers
  logic [COORD_W-1:0]       cx_q, cy_q, x_q, y_q, f_q;
  logic                     turb_q;
  logic [CELL_W-1:0]        i_q, j_q;
  logic [CELL_W-1:0]        bsel_q [4];
  logic [1:0]               k_q;
  logic signed [GRAD_BITS-1:0] gy_q;
  logic signed [PROD_W-1:0] acc_q, prod_q;
  logic signed [NV_W-1:0]   c_q [4];
  logic [15:0]              sx_q, sy_q;
  logic signed [NV_W-1:0]   a_q, bl_q;
  logic [DIV_W-1:0]         num_q;
  logic [COORD_W-1:0]       rem_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     neg_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic [VAL_W-1:0]         res_q;
  logic                     m_valid_q;
  logic [VAL_W-1:0]         m_value_q;

  // combinational helpers
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [MUL_W-1:0]  rx0, rx1, ry0, ry1, rxk, ryk;
  logic signed [GRAD_BITS-1:0] gx_s;
  logic [CELL_W-1:0]        bx0, by0, bx1, by1;
  logic signed [NV_W-1:0]   nval, nmag;
  logic [COORD_W:0]         rem_sh;
  logic                     qbit;
  logic signed [SUM_W-1:0]  sum_nx;
  logic [COORD_W-1:0]       f_nx;
  logic                     out_free;

  assign bx0 = x_q[16 +: CELL_W];
  assign by0 = y_q[16 +: CELL_W];
  assign bx1 = bx0 + CELL_W'(1);
  assign by1 = by0 + CELL_W'(1);
  assign rx0 = MUL_W'(x_q[15:0]);
  assign ry0 = MUL_W'(y_q[15:0]);
  assign rx1 = rx0 - MUL_W'(ONE_Q16);
  assign ry1 = ry0 - MUL_W'(ONE_Q16);
  assign rxk = k_q[0] ? rx1 : rx0;
  assign ryk = k_q[1] ? ry1 : ry0;
  assign gx_s = g_rdata[GRAD_BITS-1:0];

  assign nval = a_q + NV_W'(prod_q >>> 16);
  assign nmag = nval[NV_W-1] ? -nval : nval;

  assign rem_sh = {rem_q, num_q[DIV_W-1]};
  assign qbit   = (rem_sh >= {1'b0, f_q});
  assign sum_nx = neg_q ? sum_q - SUM_W'(num_q) : sum_q + SUM_W'(num_q);
  assign f_nx   = f_q >> 1;

  assign out_free = !m_valid_q || m_ready_i;

  // table writes come straight from the queue head when a load is popped
  assign p_we = (state_q == ST_IDLE) && head_valid_i && (head_i.cmd == CMD_LOAD_PERM);
  assign g_we = (state_q == ST_IDLE) && head_valid_i && (head_i.cmd == CMD_LOAD_GRAD);

  gn2t_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_perm (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (CELL_W'(head_i.entry_index)),
    .wdata_i (head_i.perm_value),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  gn2t_ram #(.WIDTH(GW), .DEPTH(TABLE_SIZE)) u_grad (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (CELL_W'(head_i.entry_index)),
    .wdata_i ({GRAD_BITS'(head_i.grad_y), GRAD_BITS'(head_i.grad_x)}),
    .raddr_i (g_raddr),
    .rdata_o (g_rdata)
  );

  // next state, store addresses and multiplier operands
  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    p_raddr = bx0;
    g_raddr = bsel_q[k_q];
    mul_a   = '0;
    mul_b   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (head_valid_i) begin
          pop_o = 1'b1;
          unique case (head_i.cmd)
            CMD_NOISE: state_d = ST_P0;
            CMD_TURB:  state_d = (head_i.start_freq[31:16] != '0) ? ST_TMX : ST_DONE;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_TMX: begin
        mul_a   = MUL_W'(signed'(cx_q));
        mul_b   = MUL_W'(f_q);
        state_d = ST_TMY;
      end
      ST_TMY: begin
        mul_a   = MUL_W'(signed'(cy_q));
        mul_b   = MUL_W'(f_q);
        state_d = ST_TXY;
      end
      ST_TXY: state_d = ST_P0;
      ST_P0:  state_d = ST_P1;
      ST_P1: begin
        p_raddr = bx1;
        state_d = ST_P2;
      end
      ST_P2: begin
        p_raddr = i_q + by0;
        state_d = ST_P3;
      end
      ST_P3: begin
        p_raddr = j_q + by0;
        state_d = ST_P4;
      end
      ST_P4: begin
        p_raddr = i_q + by1;
        state_d = ST_P5;
      end
      ST_P5: begin
        p_raddr = j_q + by1;
        state_d = ST_P6;
      end
      ST_P6:   state_d = ST_GADR;
      ST_GADR: state_d = ST_GMX;
      ST_GMX: begin
        mul_a   = rxk;
        mul_b   = MUL_W'(gx_s);
        state_d = ST_GMY;
      end
      ST_GMY: begin
        mul_a   = ryk;
        mul_b   = MUL_W'(gy_q);
        state_d = ST_GSUM;
      end
      ST_GSUM: state_d = (k_q == 2'd3) ? ST_SX1 : ST_GADR;
      ST_SX1: begin
        mul_a   = rx0;
        mul_b   = rx0;
        state_d = ST_SX2;
      end
      ST_SX2: begin
        mul_a   = MUL_W'(prod_q);
        mul_b   = MUL_W'(SMOOTH_K) - (rx0 <<< 1);
        state_d = ST_SX3;
      end
      ST_SX3: state_d = ST_SY1;
      ST_SY1: begin
        mul_a   = ry0;
        mul_b   = ry0;
        state_d = ST_SY2;
      end
      ST_SY2: begin
        mul_a   = MUL_W'(prod_q);
        mul_b   = MUL_W'(SMOOTH_K) - (ry0 <<< 1);
        state_d = ST_SY3;
      end
      ST_SY3: state_d = ST_BA;
      ST_BA: begin
        mul_a   = MUL_W'(sx_q);
        mul_b   = MUL_W'(c_q[1] - c_q[0]);
        state_d = ST_BB;
      end
      ST_BB: begin
        mul_a   = MUL_W'(sx_q);
        mul_b   = MUL_W'(c_q[3] - c_q[2]);
        state_d = ST_BC;
      end
      ST_BC: state_d = ST_BD;
      ST_BD: begin
        mul_a   = MUL_W'(sy_q);
        mul_b   = MUL_W'(bl_q - a_q);
        state_d = ST_BE;
      end
      ST_BE:  state_d = turb_q ? ST_DIV : ST_DONE;
      ST_DIV: state_d = (cnt_q == CNT_W'(DIV_W - 1)) ? ST_ACC : ST_DIV;
      ST_ACC: state_d = (f_nx[31:16] != '0) ? ST_TMX : ST_DONE;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (state_q)
      ST_IDLE: begin
        cx_q   <= head_i.coord_x;
        cy_q   <= head_i.coord_y;
        x_q    <= head_i.coord_x;
        y_q    <= head_i.coord_y;
        f_q    <= head_i.start_freq;
        turb_q <= (head_i.cmd == CMD_TURB);
        sum_q  <= '0;
        res_q  <= VAL_W'(HALF_Q16);
      end
      ST_TMY: x_q <= prod_q[47:16];
      ST_TXY: y_q <= prod_q[47:16];
      ST_P1:  i_q <= CELL_W'(p_rdata);
      ST_P2:  j_q <= CELL_W'(p_rdata);
      ST_P3:  bsel_q[0] <= CELL_W'(p_rdata);
      ST_P4:  bsel_q[1] <= CELL_W'(p_rdata);
      ST_P5:  bsel_q[2] <= CELL_W'(p_rdata);
      ST_P6: begin
        bsel_q[3] <= CELL_W'(p_rdata);
        k_q       <= 2'd0;
      end
      ST_GMX: gy_q <= g_rdata[GW-1:GRAD_BITS];
      ST_GMY: acc_q <= prod_q;
      ST_GSUM: begin
        c_q[k_q] <= NV_W'((acc_q + prod_q) >>> 14);
        k_q      <= k_q + 2'd1;
      end
      ST_SX3: sx_q <= prod_q[47:32];
      ST_SY3: sy_q <= prod_q[47:32];
      ST_BB:  a_q  <= c_q[0] + NV_W'(prod_q >>> 16);
      ST_BC:  bl_q <= c_q[2] + NV_W'(prod_q >>> 16);
      ST_BE: begin
        res_q <= sat_val(nval);
        neg_q <= nval[NV_W-1];
        num_q <= DIV_W'(nmag) << 16;
        rem_q <= '0;
        cnt_q <= '0;
      end
      ST_DIV: begin
        rem_q <= qbit ? COORD_W'(rem_sh - {1'b0, f_q}) : COORD_W'(rem_sh);
        num_q <= {num_q[DIV_W-2:0], qbit};
        cnt_q <= cnt_q + CNT_W'(1);
      end
      ST_ACC: begin
        sum_q <= sum_nx;
        f_q   <= f_nx;
        res_q <= sat_val(NV_W'(sum_nx >>> 1) + NV_W'(HALF_Q16));
      end
      default: ;
    endcase
    if (state_q == ST_DONE && out_free) begin
      m_value_q <= res_q;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_value_o = m_value_q;

`ifndef SYNTH
  a_done_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (m_valid_q && state_q == ST_IDLE))
    else $error("result not handed to output register");
  a_octave_freq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TMX) |-> (f_q[31:16] != '0))
    else $error("octave started with frequency below one");
  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == ST_IDLE && head_valid_i))
    else $error("queue popped while busy");
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && $past(state_q) == ST_BE) |-> (cnt_q == '0))
    else $error("divider started with stale count");
`endif

endmodule
